/* design/tlbat_pkg.sv */
// package for the tlb address translation block
// types, constants and codes shared by the front, queue, back and top level; no dependencies
package tlbat_pkg;

    localparam int TLB_ENTRIES_DEF = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] MATCH_BITS = 64'hc00000ffffffe000;
    localparam logic [31:0] PMASK_BITS = 32'h01ffe000;

    typedef enum logic [2:0] {
        FLT_NONE     = 3'd0,
        FLT_ADDR     = 3'd1,
        FLT_REFILL   = 3'd2,
        FLT_INVALID  = 3'd3,
        FLT_MODIFIED = 3'd4
    } t_fault;

    typedef enum logic [1:0] {
        ACC_READ  = 2'd0,
        ACC_WRITE = 2'd1,
        ACC_FETCH = 2'd2
    } t_access;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_WRITE     = 1'b1;

    localparam logic [1:0] REG_PRIV  = 2'd0;
    localparam logic [1:0] REG_WIDE  = 2'd1;
    localparam logic [1:0] REG_ASID  = 2'd2;

    localparam logic [1:0] PRIV_KERNEL = 2'd0;
    localparam logic [1:0] PRIV_SUPER  = 2'd1;

    // classified request passed from front to back
    typedef struct packed {
        logic        is_write;
        logic        is_direct;   // unmapped, result already known
        logic        is_fault;    // address error
        logic [31:0] direct_pa;
        logic        direct_cached;
        logic [63:0] va;
        logic [1:0]  acc;
        logic [4:0]  slot;
        logic [31:0] pmask;
        logic [63:0] vpn_hi;
        logic        global_bit;
        logic [31:0] lo_even;
        logic [31:0] lo_odd;
    } t_req;

endpackage

/* design/tlbat_if.sv */
// valid/ready channel interface carrying a packed payload
// depends on nothing
interface tlbat_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/tlbat_in_t.sv */
// input and output payload types used on the top-level channels
// depends on nothing
package tlbat_io_pkg;
    typedef struct packed {
        logic        op;
        logic [63:0] virtual_address;
        logic [1:0]  access_kind;
        logic [4:0]  entry_slot;
        logic [24:0] entry_page_mask;
        logic [63:0] entry_vpn_hi;
        logic        entry_global;
        logic [31:0] entry_lo_even;
        logic [31:0] entry_lo_odd;
    } t_in_item;

    typedef struct packed {
        logic [31:0] physical_address;
        logic        cached;
        logic [2:0]  fault;
        logic        fault_on_store;
        logic        fault_on_fetch;
        logic [63:0] bad_vpn_hi;
        logic [22:0] context_vpn;
        logic [32:0] xcontext_vpn;
    } t_out_item;
endpackage

/* design/tlbat_front.sv */
// front: segment and privilege check, classifies each request
// depends on tlbat_pkg and tlbat_io_pkg
module tlbat_front
    import tlbat_pkg::*;
    import tlbat_io_pkg::*;
(
    input  logic       i_kernel,
    input  logic       i_super,
    input  logic       i_wide,
    input  t_in_item   i_item,
    output t_req       o_req
);
    logic [63:0] va;
    logic [31:0] low;
    logic        compat;
    logic        mapped;
    logic        direct;
    logic [31:0] dpa;
    logic        dcached;
    logic [1:0]  region;

    always_comb begin
        va = i_item.virtual_address;
        low = va[31:0];
        compat = (va[63:32] == {32{low[31]}});
        region = va[63:62];
        mapped = 1'b0;
        direct = 1'b0;
        dpa = '0;
        dcached = 1'b0;
        if (compat) begin
            if (!low[31]) begin
                mapped = 1'b1;
            end else if (i_kernel && low < 32'hc0000000) begin
                direct = 1'b1;
                dpa = low & 32'h1fffffff;
                dcached = low < 32'ha0000000;
            end else if ((i_kernel || i_super) && low >= 32'hc0000000
                         && low < 32'he0000000) begin
                mapped = 1'b1;
            end else if (i_kernel && low >= 32'he0000000) begin
                mapped = 1'b1;
            end
        end else if (i_wide) begin
            case (region)
                2'd0: mapped = va <= 64'h000000ffffffffff;
                2'd1: mapped = (i_kernel || i_super) && va <= 64'h400000ffffffffff;
                2'd2: begin
                    if (i_kernel && (va & 64'h07ffffff00000000) == '0) begin
                        direct = 1'b1;
                        dpa = low;
                        dcached = va[61:59] != 3'd2;
                    end
                end
                default: mapped = i_kernel && va <= 64'hc00000ff7fffffff;
            endcase
        end
        o_req.is_write = i_item.op == OP_WRITE;
        o_req.is_direct = direct;
        o_req.is_fault = !direct && !mapped;
        o_req.direct_pa = dpa;
        o_req.direct_cached = dcached;
        o_req.va = va;
        o_req.acc = i_item.access_kind;
        o_req.slot = i_item.entry_slot;
        o_req.pmask = {7'd0, i_item.entry_page_mask} & PMASK_BITS;
        o_req.vpn_hi = i_item.entry_vpn_hi;
        o_req.global_bit = i_item.entry_global;
        o_req.lo_even = i_item.entry_lo_even;
        o_req.lo_odd = i_item.entry_lo_odd;
    end
endmodule

/* design/tlbat_queue.sv */
// short fifo between front and back
// depends on tlbat_pkg
module tlbat_queue
    import tlbat_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_req o_data
);
    t_req       r_mem [QUEUE_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full = r_cnt == 2'(QUEUE_DEPTH);
    assign o_empty = r_cnt == 2'd0;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

/* design/tlbat_back.sv */
// back: walks the tlb one slot a cycle, writes entries, builds results
// depends on tlbat_pkg and tlbat_io_pkg
module tlbat_back
    import tlbat_pkg::*;
    import tlbat_io_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [7:0] i_asid,
    input  logic      i_empty,
    input  t_req      i_req,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int CW = $clog2(TLB_ENTRIES + 1);

    logic [63:0] r_vpn [TLB_ENTRIES];
    logic [31:0] r_pm  [TLB_ENTRIES];
    logic [31:0] r_loe [TLB_ENTRIES];
    logic [31:0] r_loo [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_glb;
    logic [TLB_ENTRIES-1:0] r_vld;   // entry written since reset

    logic          r_busy;
    logic [CW-1:0] r_idx;
    logic          r_ovalid;
    t_out_item     r_oitem;

    logic [IW-1:0] idx;
    logic [63:0]   e_vpn, m;
    logic [31:0]   e_pm, e_lo, offm;
    logic          e_glb, hit, done;
    t_out_item     res, flt;
    logic [2:0]    fk;
    logic          start, outfree;

    assign o_valid = r_ovalid;
    assign o_item = r_oitem;
    assign outfree = !r_ovalid || i_ready;
    assign start = !r_busy && !i_empty;

    always_comb begin
        idx = r_idx[IW-1:0];
        e_vpn = r_vld[idx] ? r_vpn[idx] : '0;
        e_pm  = r_vld[idx] ? r_pm[idx]  : '0;
        e_glb = r_vld[idx] ? r_glb[idx] : 1'b0;
        m = MATCH_BITS & ~{32'd0, e_pm};
        hit = ((i_req.va & m) == (e_vpn & m))
            && (e_glb || e_vpn[7:0] == i_asid);
        offm = (e_pm | 32'h1fff) >> 1;
        e_lo = ((i_req.va[31:0] & (offm + 32'd1)) != '0)
            ? (r_vld[idx] ? r_loo[idx] : '0) : (r_vld[idx] ? r_loe[idx] : '0);

        flt = '0;
        flt.fault_on_store = i_req.acc == ACC_WRITE;
        flt.fault_on_fetch = i_req.acc == ACC_FETCH;
        flt.bad_vpn_hi = i_req.va & MATCH_BITS;
        flt.context_vpn = 23'((i_req.va >> 9) & 64'h7ffff0);
        flt.xcontext_vpn = 33'(((i_req.va >> 9) & 64'h7ffffff0)
            | ((i_req.va >> 31) & 64'h180000000));

        res = '0;
        done = 1'b0;
        fk = FLT_NONE;
        if (start) begin
            if (i_req.is_write) begin
                done = 1'b1;
            end else if (i_req.is_direct) begin
                done = 1'b1;
                res.physical_address = i_req.direct_pa;
                res.cached = i_req.direct_cached;
            end else if (i_req.is_fault) begin
                done = 1'b1;
                fk = FLT_ADDR;
            end
        end else if (r_busy) begin
            if (r_idx == CW'(TLB_ENTRIES)) begin
                done = 1'b1;
                fk = FLT_REFILL;
            end else if (hit) begin
                done = 1'b1;
                if (!e_lo[1]) fk = FLT_INVALID;
                else if (i_req.acc == ACC_WRITE && !e_lo[2]) fk = FLT_MODIFIED;
                else begin
                    res.physical_address = ((e_lo >> 6) << 12)
                        + (i_req.va[31:0] & offm);
                    res.cached = e_lo[5:3] != 3'd2;
                end
            end
        end
        if (fk != FLT_NONE) begin
            res = flt;
            res.fault = fk;
        end
        o_pop = done && outfree;
    end

    always_ff @(posedge i_clk) begin
        if (start && i_req.is_write && outfree
            && {2'b0, i_req.slot} < 7'(TLB_ENTRIES)) begin
            r_vpn[IW'(i_req.slot)] <= i_req.vpn_hi;
            r_pm[IW'(i_req.slot)]  <= i_req.pmask;
            r_loe[IW'(i_req.slot)] <= i_req.lo_even;
            r_loo[IW'(i_req.slot)] <= i_req.lo_odd;
        end
        if (o_pop) r_oitem <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= '0;
            r_ovalid <= 1'b0;
            r_vld <= '0;
            r_glb <= '0;
        end else begin
            if (start && i_req.is_write && outfree
                && {2'b0, i_req.slot} < 7'(TLB_ENTRIES)) begin
                r_vld[IW'(i_req.slot)] <= 1'b1;
                r_glb[IW'(i_req.slot)] <= i_req.global_bit;
            end
            if (o_pop) begin
                r_busy <= 1'b0;
                r_idx <= '0;
            end else if (start && !done) begin
                r_busy <= 1'b1;
                r_idx <= '0;
            end else if (r_busy && !done) begin
                r_idx <= r_idx + CW'(1);
            end
            if (o_pop) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end
endmodule

/* design/tlb_address_translation.sv */
// top level of the tlb address translation block
// depends on tlbat_pkg, tlbat_io_pkg, tlbat_if, tlbat_front, tlbat_queue, tlbat_back
//
// channel   dir  handshake        payload
// i_in      in   valid/ready      t_in_item (op, address, entry fields)
// o_out     out  valid/ready      t_out_item (address, fault, vpn fields)
// apb       in   psel/penable     privilege, wide addressing, asid
//
// unmapped, faulting and write requests finish in the back end without a scan;
// mapped lookups begin with a start step, then scan one tlb slot a cycle,
// and report a refill fault when no slot matches.
// a two-entry queue lets the front accept while the back scans.
// synchronous active-low reset clears control state and the valid bit of every tlb entry, so entries read as zero.
module tlb_address_translation
    import tlbat_pkg::*;
    import tlbat_io_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlbat_if.sink       i_in,
    tlbat_if.source     o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [1:0] r_priv;
    logic       r_wide;
    logic [7:0] r_asid;
    t_req       req_f, req_q;
    logic       full, empty, pop, push;

    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            REG_PRIV: prdata = {30'd0, r_priv};
            REG_WIDE: prdata = {31'd0, r_wide};
            REG_ASID: prdata = {24'd0, r_asid};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_priv <= '0;
            r_wide <= 1'b0;
            r_asid <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_PRIV: r_priv <= pwdata[1:0];
                REG_WIDE: r_wide <= pwdata[0];
                REG_ASID: r_asid <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = !full;
    assign push = i_in.valid && !full;

    tlbat_front u_front (
        .i_kernel (r_priv == PRIV_KERNEL),
        .i_super  (r_priv == PRIV_SUPER),
        .i_wide   (r_wide),
        .i_item   (i_in.payload),
        .o_req    (req_f)
    );

    tlbat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (req_f),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (req_q)
    );

    tlbat_back #(.TLB_ENTRIES(TLB_ENTRIES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_asid  (r_asid),
        .i_empty (empty),
        .i_req   (req_q),
        .o_pop   (pop),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_item  (o_out.payload)
    );
endmodule
